// ===== rtl/core/ssd_pkg.sv =====
// Shared types, widths and helper functions for the segment distance pipeline.
// No dependencies; every other file in rtl/core imports this package.
package ssd_pkg;

   localparam int COORD_BITS   = 16;
   localparam int FRAC_BITS    = 8;
   localparam int NUM_COORDS   = 12;
   localparam int IN_W         = NUM_COORDS * COORD_BITS;
   localparam int OUT_W        = 17;
   localparam int OUT_TDATA_W  = 24;
   localparam int DIFF_W       = COORD_BITS + 1;
   localparam int SQ_W         = 2 * DIFF_W;
   localparam int DOT_W        = SQ_W + 2;
   localparam int PROD_W       = 2 * DOT_W;
   localparam int WIDE_W       = PROD_W + 4;
   localparam int PARAM_FRAC   = 32;
   localparam int CMP_W        = 53;
   localparam int QR_W         = 28;
   localparam int SUM_W        = 58;
   localparam int ROOT_STEPS   = 29;
   localparam int LIFT_SHIFT   = 2 * FRAC_BITS;
   localparam int ROUND_SHIFT  = PARAM_FRAC - FRAC_BITS;

   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [DOT_W-1:0]   dot_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic [PARAM_FRAC:0]       ratio_type;
   typedef logic [SUM_W-1:0]          sum_type;

   // Anything at or below this magnitude counts as zero (threshold 0.005 in Q.4F)
   localparam wide_type SMALL_LIMIT =
      WIDE_W'(((64'd1 << (4 * FRAC_BITS)) - 64'd1) / 64'd200);
   localparam wide_type ONE_Q4 = WIDE_W'(64'd1 << (4 * FRAC_BITS));

   typedef struct packed {
      diff_type x;
      diff_type y;
      diff_type z;
   } vec_type;

   typedef struct packed {
      vec_type u;
      vec_type v;
      vec_type w;
   } geom_type;

   typedef struct packed {
      geom_type g;
      dot_type  a;
      dot_type  b;
      dot_type  c;
      dot_type  d;
      dot_type  e;
      wide_type dd;
      wide_type sn;
      wide_type tn;
   } front_type;

   typedef struct packed {
      geom_type g;
      wide_type sn;
      wide_type sd;
      wide_type tn;
      wide_type td;
   } quot_in_type;

   typedef struct packed {
      geom_type  g;
      ratio_type sc;
      ratio_type tc;
   } quot_out_type;

   function automatic wide_type to_wide(input dot_type x);
      to_wide = {{(WIDE_W - DOT_W){x[DOT_W-1]}}, x};
   endfunction

   // Q.2F dot-product scale to Q.4F
   function automatic wide_type lift(input wide_type x);
      lift = x <<< LIFT_SHIFT;
   endfunction

endpackage

// ===== rtl/core/segment_segment_distance_3d.sv =====
// Channel  Dir  Ports                       Contents
// req      in   req_tvalid/tready/tdata     12 signed Q8.8 endpoint coordinates
// rsp      out  rsp_tvalid/tready/tdata     gap_length, unsigned Q9.8, saturating
//
// One request enters per cycle while the skid register is empty; each result passes
// through the front, clamp, divider, length and root, and output registers in turn,
// with the divider and square root resolving one bit per stage.
// Reset (synchronous, active high) clears only the valid bits of every stage.
// A stalled result parks in a skid register so one more request is taken; the
// whole pipeline then holds until the skid register drains.
//
// Top level of the 3D segment-to-segment distance pipeline.
// Depends on ssd_pkg, ssd_front, ssd_select, ssd_div and ssd_norm.
module segment_segment_distance_3d
   import ssd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
   // b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z (16 bits each)
   input  logic [IN_W-1:0]        req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // gap_length [16:0], zero fill above
   output logic [OUT_TDATA_W-1:0] rsp_tdata
);

   logic             advance;
   logic             front_valid, sel_valid, div_valid, norm_valid;
   front_type        front_data;
   quot_in_type      sel_data;
   quot_out_type     div_data;
   sum_type          norm_root;

   logic [OUT_W-1:0] gap;
   logic             rsp_valid_ff, skid_valid_ff;
   logic [OUT_W-1:0] rsp_data_ff, skid_data_ff;
   logic             fresh;

   // Hold every stage while the skid register is occupied
   assign advance    = !skid_valid_ff;
   assign req_tready = advance;

   ssd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   ssd_select u_select (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (sel_valid),
      .out_data  (sel_data)
   );

   ssd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sel_valid),
      .in_data   (sel_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   ssd_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (norm_valid),
      .out_root  (norm_root)
   );

   // Round the Q.2F root half up to Q.F, then saturate
   always_comb begin
      sum_type rnd;
      rnd = norm_root + (SUM_W'(1) << (FRAC_BITS - 1));
      if (rnd[SUM_W-1:FRAC_BITS] > (SUM_W - FRAC_BITS)'(OUT_MAX)) begin
         gap = OUT_MAX;
      end else begin
         gap = rnd[FRAC_BITS +: OUT_W];
      end
   end

   // A new result leaves the last stage only when the pipeline moves
   assign fresh = norm_valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= fresh;
         end
      end else if (fresh) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_tready) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : gap;
      end else if (fresh) begin
         skid_data_ff <= gap;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, rsp_data_ff};

endmodule

// ===== rtl/core/ssd_front.sv =====
// Front of the pipeline: differences, dot products, products of dot products, D and numerators.
// Four register stages; depends on ssd_pkg.
module ssd_front
   import ssd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [IN_W-1:0]  in_data,
   output logic             out_valid,
   output front_type        out_data
);

   typedef struct packed {
      geom_type g;
      dot_type  a;
      dot_type  b;
      dot_type  c;
      dot_type  d;
      dot_type  e;
   } dots_type;

   typedef struct packed {
      dots_type dt;
      prod_type ac;
      prod_type bb;
      prod_type be;
      prod_type cd;
      prod_type ae;
      prod_type bd;
   } prods_type;

   function automatic diff_type coord(input int idx, input logic [IN_W-1:0] data);
      logic signed [COORD_BITS-1:0] raw;
      raw   = data[idx*COORD_BITS +: COORD_BITS];
      coord = DIFF_W'(raw);
   endfunction

   function automatic dot_type dot(input vec_type p, input vec_type q);
      logic signed [SQ_W-1:0] px;
      logic signed [SQ_W-1:0] py;
      logic signed [SQ_W-1:0] pz;
      px  = p.x * q.x;
      py  = p.y * q.y;
      pz  = p.z * q.z;
      dot = DOT_W'(px) + DOT_W'(py) + DOT_W'(pz);
   endfunction

   logic      v1_ff, v2_ff, v3_ff, v4_ff;
   geom_type  g1_in, g1_ff;
   dots_type  d2_in, d2_ff;
   prods_type p3_in, p3_ff;
   front_type f4_in, f4_ff;

   always_comb begin
      g1_in.u.x = coord(3, in_data) - coord(0, in_data);
      g1_in.u.y = coord(4, in_data) - coord(1, in_data);
      g1_in.u.z = coord(5, in_data) - coord(2, in_data);
      g1_in.v.x = coord(9, in_data) - coord(6, in_data);
      g1_in.v.y = coord(10, in_data) - coord(7, in_data);
      g1_in.v.z = coord(11, in_data) - coord(8, in_data);
      g1_in.w.x = coord(6, in_data) - coord(0, in_data);
      g1_in.w.y = coord(7, in_data) - coord(1, in_data);
      g1_in.w.z = coord(8, in_data) - coord(2, in_data);
   end

   always_comb begin
      d2_in.g = g1_ff;
      d2_in.a = dot(g1_ff.u, g1_ff.u);
      d2_in.b = dot(g1_ff.u, g1_ff.v);
      d2_in.c = dot(g1_ff.v, g1_ff.v);
      d2_in.d = dot(g1_ff.u, g1_ff.w);
      d2_in.e = dot(g1_ff.v, g1_ff.w);
   end

   always_comb begin
      p3_in.dt = d2_ff;
      p3_in.ac = d2_ff.a * d2_ff.c;
      p3_in.bb = d2_ff.b * d2_ff.b;
      p3_in.be = d2_ff.b * d2_ff.e;
      p3_in.cd = d2_ff.c * d2_ff.d;
      p3_in.ae = d2_ff.a * d2_ff.e;
      p3_in.bd = d2_ff.b * d2_ff.d;
   end

   always_comb begin
      f4_in.g  = p3_ff.dt.g;
      f4_in.a  = p3_ff.dt.a;
      f4_in.b  = p3_ff.dt.b;
      f4_in.c  = p3_ff.dt.c;
      f4_in.d  = p3_ff.dt.d;
      f4_in.e  = p3_ff.dt.e;
      f4_in.dd = WIDE_W'(p3_ff.ac) - WIDE_W'(p3_ff.bb);
      f4_in.sn = WIDE_W'(p3_ff.be) - WIDE_W'(p3_ff.cd);
      f4_in.tn = WIDE_W'(p3_ff.ae) - WIDE_W'(p3_ff.bd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         g1_ff <= g1_in;
         d2_ff <= d2_in;
         p3_ff <= p3_in;
         f4_ff <= f4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = f4_ff;

endmodule

// ===== rtl/core/ssd_select.sv =====
// Parallel test and clamping of the s and t numerators and denominators.
// Two register stages; depends on ssd_pkg.
module ssd_select
   import ssd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  front_type   in_data,
   output logic        out_valid,
   output quot_in_type out_data
);

   typedef struct packed {
      geom_type g;
      dot_type  a;
      dot_type  b;
      dot_type  d;
      wide_type sn;
      wide_type sd;
      wide_type tn;
      wide_type td;
   } clamp_type;

   logic        v1_ff, v2_ff;
   clamp_type   c1_in, c1_ff;
   quot_in_type q2_in, q2_ff;

   // First pass: parallel case, then clamp s to its edges
   always_comb begin
      c1_in.g  = in_data.g;
      c1_in.a  = in_data.a;
      c1_in.b  = in_data.b;
      c1_in.d  = in_data.d;
      c1_in.sd = in_data.dd;
      c1_in.td = in_data.dd;
      c1_in.sn = in_data.sn;
      c1_in.tn = in_data.tn;
      if (in_data.dd <= SMALL_LIMIT) begin
         c1_in.sn = '0;
         c1_in.sd = ONE_Q4;
         c1_in.tn = lift(to_wide(in_data.e));
         c1_in.td = lift(to_wide(in_data.c));
      end else if (in_data.sn[WIDE_W-1]) begin
         c1_in.sn = '0;
         c1_in.tn = lift(to_wide(in_data.e));
         c1_in.td = lift(to_wide(in_data.c));
      end else if (in_data.sn > in_data.dd) begin
         c1_in.sn = in_data.dd;
         c1_in.tn = lift(to_wide(in_data.e) + to_wide(in_data.b));
         c1_in.td = lift(to_wide(in_data.c));
      end
   end

   // Second pass: clamp t, and redo s against the clamped t
   always_comb begin
      wide_type nd;
      logic     redo;
      nd   = c1_ff.tn[WIDE_W-1] ? -to_wide(c1_ff.d) : to_wide(c1_ff.b) - to_wide(c1_ff.d);
      redo = c1_ff.tn[WIDE_W-1] || (c1_ff.tn > c1_ff.td);
      q2_in.g  = c1_ff.g;
      q2_in.sn = c1_ff.sn;
      q2_in.sd = c1_ff.sd;
      q2_in.td = c1_ff.td;
      q2_in.tn = c1_ff.tn;
      if (c1_ff.tn[WIDE_W-1]) begin
         q2_in.tn = '0;
      end else if (c1_ff.tn > c1_ff.td) begin
         q2_in.tn = c1_ff.td;
      end
      if (redo) begin
         if (nd[WIDE_W-1]) begin
            q2_in.sn = '0;
         end else if (nd > to_wide(c1_ff.a)) begin
            q2_in.sn = c1_ff.sd;
         end else begin
            q2_in.sn = lift(nd);
            q2_in.sd = lift(to_wide(c1_ff.a));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_ff <= c1_in;
         q2_ff <= q2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = q2_ff;

endmodule

// ===== rtl/core/ssd_div.sv =====
// Pipelined restoring divider for the s and t ratios, one quotient bit per stage.
// Entry stage plus PARAM_FRAC step stages; depends on ssd_pkg.
module ssd_div
   import ssd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  quot_in_type  in_data,
   output logic         out_valid,
   output quot_out_type out_data
);

   typedef struct packed {
      logic                  zero;
      logic                  one;
      logic [WIDE_W-1:0]     rem;
      logic [WIDE_W-1:0]     den;
      logic [PARAM_FRAC-1:0] quo;
   } lane_type;

   typedef struct packed {
      geom_type g;
      lane_type s;
      lane_type t;
   } step_type;

   function automatic lane_type lane_start(input wide_type n, input wide_type d);
      wide_type mag;
      mag                 = n[WIDE_W-1] ? -n : n;
      lane_start.zero     = (mag <= SMALL_LIMIT) || n[WIDE_W-1] || (d <= 0);
      lane_start.one      = (n >= d);
      lane_start.rem      = n;
      lane_start.den      = d;
      lane_start.quo      = '0;
   endfunction

   function automatic lane_type lane_step(input lane_type l);
      logic [WIDE_W-1:0] sh;
      sh        = l.rem << 1;
      lane_step = l;
      if (sh >= l.den) begin
         lane_step.rem = sh - l.den;
         lane_step.quo = {l.quo[PARAM_FRAC-2:0], 1'b1};
      end else begin
         lane_step.rem = sh;
         lane_step.quo = {l.quo[PARAM_FRAC-2:0], 1'b0};
      end
   endfunction

   function automatic ratio_type lane_result(input lane_type l);
      if (l.zero) begin
         lane_result = '0;
      end else if (l.one) begin
         lane_result = {1'b1, {PARAM_FRAC{1'b0}}};
      end else begin
         lane_result = {1'b0, l.quo};
      end
   endfunction

   logic     v_ff [0:PARAM_FRAC];
   step_type st_ff [0:PARAM_FRAC];
   step_type st_in [0:PARAM_FRAC];

   always_comb begin
      st_in[0].g = in_data.g;
      st_in[0].s = lane_start(in_data.sn, in_data.sd);
      st_in[0].t = lane_start(in_data.tn, in_data.td);
   end

   for (genvar i = 1; i <= PARAM_FRAC; i++) begin : g_step
      always_comb begin
         st_in[i].g = st_ff[i-1].g;
         st_in[i].s = lane_step(st_ff[i-1].s);
         st_in[i].t = lane_step(st_ff[i-1].t);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= PARAM_FRAC; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i <= PARAM_FRAC; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i <= PARAM_FRAC; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign out_valid   = v_ff[PARAM_FRAC];
   assign out_data.g  = st_ff[PARAM_FRAC].g;
   assign out_data.sc = lane_result(st_ff[PARAM_FRAC].s);
   assign out_data.tc = lane_result(st_ff[PARAM_FRAC].t);

endmodule

// ===== rtl/core/ssd_norm.sv =====
// Closest-point offset, rounding, squared length and pipelined integer square root.
// Four arithmetic stages plus ROOT_STEPS root stages; depends on ssd_pkg.
module ssd_norm
   import ssd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  quot_out_type in_data,
   output logic         out_valid,
   output sum_type      out_root
);

   typedef logic signed [CMP_W-1:0] cmp_type;
   typedef logic [QR_W-1:0]         qr_type;
   typedef logic [2*QR_W-1:0]       sq_type;

   typedef struct packed {
      cmp_type x;
      cmp_type y;
      cmp_type z;
   } cmp3_type;

   typedef struct packed {
      qr_type x;
      qr_type y;
      qr_type z;
   } qr3_type;

   typedef struct packed {
      sq_type x;
      sq_type y;
      sq_type z;
   } sq3_type;

   typedef struct packed {
      sum_type n;
      sum_type r;
   } root_type;

   function automatic cmp_type offset(input diff_type w, input diff_type u,
                                      input diff_type v, input ratio_type sc,
                                      input ratio_type tc);
      logic signed [PARAM_FRAC+DIFF_W:0] su;
      logic signed [PARAM_FRAC+DIFF_W:0] tv;
      su     = $signed({1'b0, sc}) * u;
      tv     = $signed({1'b0, tc}) * v;
      offset = (CMP_W'(w) <<< PARAM_FRAC) + CMP_W'(su) - CMP_W'(tv);
   endfunction

   function automatic qr_type round_mag(input cmp_type c);
      logic [CMP_W-1:0] mag;
      logic [CMP_W-1:0] rnd;
      mag       = c[CMP_W-1] ? -c : c;
      rnd       = mag + (CMP_W'(1) << (ROUND_SHIFT - 1));
      round_mag = rnd[ROUND_SHIFT +: QR_W];
   endfunction

   logic     v1_ff, v2_ff, v3_ff, v4_ff;
   cmp3_type c1_in, c1_ff;
   qr3_type  q2_in, q2_ff;
   sq3_type  s3_in, s3_ff;
   sum_type  sum4_in, sum4_ff;

   logic     rv_ff [0:ROOT_STEPS-1];
   root_type rt_ff [0:ROOT_STEPS-1];
   root_type rt_in [0:ROOT_STEPS-1];
   root_type rt_src [0:ROOT_STEPS-1];

   always_comb begin
      c1_in.x = offset(in_data.g.w.x, in_data.g.u.x, in_data.g.v.x, in_data.sc, in_data.tc);
      c1_in.y = offset(in_data.g.w.y, in_data.g.u.y, in_data.g.v.y, in_data.sc, in_data.tc);
      c1_in.z = offset(in_data.g.w.z, in_data.g.u.z, in_data.g.v.z, in_data.sc, in_data.tc);
   end

   always_comb begin
      q2_in.x = round_mag(c1_ff.x);
      q2_in.y = round_mag(c1_ff.y);
      q2_in.z = round_mag(c1_ff.z);
   end

   always_comb begin
      s3_in.x = q2_ff.x * q2_ff.x;
      s3_in.y = q2_ff.y * q2_ff.y;
      s3_in.z = q2_ff.z * q2_ff.z;
   end

   assign sum4_in = SUM_W'(s3_ff.x) + SUM_W'(s3_ff.y) + SUM_W'(s3_ff.z);

   // Digit-by-digit root: each stage tries one result bit, highest first
   assign rt_src[0].n = sum4_ff;
   assign rt_src[0].r = '0;

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      localparam sum_type BIT = SUM_W'(1) << (2 * (ROOT_STEPS - 1 - k));
      if (k > 0) begin : g_link
         assign rt_src[k] = rt_ff[k-1];
      end
      always_comb begin
         sum_type trial;
         trial = rt_src[k].r + BIT;
         if (rt_src[k].n >= trial) begin
            rt_in[k].n = rt_src[k].n - trial;
            rt_in[k].r = (rt_src[k].r >> 1) + BIT;
         end else begin
            rt_in[k].n = rt_src[k].n;
            rt_in[k].r = rt_src[k].r >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         for (int k = 0; k < ROOT_STEPS; k++) begin
            rv_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         v1_ff    <= in_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         rv_ff[0] <= v4_ff;
         for (int k = 1; k < ROOT_STEPS; k++) begin
            rv_ff[k] <= rv_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c1_ff   <= c1_in;
         q2_ff   <= q2_in;
         s3_ff   <= s3_in;
         sum4_ff <= sum4_in;
         for (int k = 0; k < ROOT_STEPS; k++) begin
            rt_ff[k] <= rt_in[k];
         end
      end
   end

   assign out_valid = rv_ff[ROOT_STEPS-1];
   assign out_root  = rt_ff[ROOT_STEPS-1].r;

endmodule

// ===== sim/segment_segment_distance_3d_test.sv =====
// Self-checking bench for the 3D segment-to-segment distance pipeline.
// Depends on ssd_pkg and the segment_segment_distance_3d top level.
module segment_segment_distance_3d_test
   import ssd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Q1.32 parameters and Q.4F threshold used by the predictor
   localparam int        QFRAC      = 32;
   localparam logic [127:0] NEAR_ZERO = ((128'd1 << 32) - 128'd1) / 128'd200;
   localparam logic [127:0] UNIT_Q4   = 128'd1 << 32;
   localparam int        LATENCY    = 73;
   localparam int        IDLE_LIMIT = 4000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
   // b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z (16 bits each)
   logic [IN_W-1:0]        req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // gap_length [16:0], zero fill above
   logic [OUT_TDATA_W-1:0] rsp_tdata;

   logic [IN_W-1:0]  pending_segments[$];
   logic [OUT_W-1:0] expected_gaps[$];
   int   error_count = 0;
   int   quiet_cycles = 0;
   bit   stim_done = 1'b0;
   bit   hold_sender = 1'b0;
   bit   no_idle = 1'b0;

   segment_segment_distance_3d u_dut (.*);

   always #6 clock = ~clock;

   // Clamp n/d to a Q1.32 fraction in [0, 1], snapping small or negative numerators to zero.
   function automatic logic [63:0] clamp_ratio(input logic signed [127:0] n,
                                              input logic signed [127:0] d);
      logic signed [127:0] mag;
      logic [63:0] q;
      mag = n < 0 ? -n : n;
      if (mag <= $signed(NEAR_ZERO) || n < 0 || d <= 0) return 64'd0;
      if (n >= d) return 64'd1 << QFRAC;
      q = 64'((n <<< QFRAC) / d);
      return q;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [OUT_W-1:0] predict_gap(input logic [IN_W-1:0] pts);
      logic signed [63:0] u[3], v[3], w[3];
      logic signed [63:0] a, b, c, d, e, nd, comp;
      logic signed [127:0] dd, sn, sd, tn, td;
      logic [63:0] sc, tc, mag, q, sum, r, g;
      bit   redo_s;
      a = 0; b = 0; c = 0; d = 0; e = 0; sum = 0;
      for (int k = 0; k < 3; k++) begin
         u[k] = $signed(pts[(3+k)*16 +: 16]) - $signed(pts[k*16 +: 16]);
         v[k] = $signed(pts[(9+k)*16 +: 16]) - $signed(pts[(6+k)*16 +: 16]);
         w[k] = $signed(pts[(6+k)*16 +: 16]) - $signed(pts[k*16 +: 16]);
         a += u[k] * u[k];
         b += u[k] * v[k];
         c += v[k] * v[k];
         d += u[k] * w[k];
         e += v[k] * w[k];
      end
      dd = 128'(a) * 128'(c) - 128'(b) * 128'(b);
      sd = dd;
      td = dd;
      // near-parallel: pin s to the start of A
      if (dd <= $signed(NEAR_ZERO)) begin
         sn = 0;
         sd = UNIT_Q4;
         tn = 128'(e) <<< 16;
         td = 128'(c) <<< 16;
      end else begin
         sn = 128'(b) * 128'(e) - 128'(c) * 128'(d);
         tn = 128'(a) * 128'(e) - 128'(b) * 128'(d);
         if (sn < 0) begin
            sn = 0;
            tn = 128'(e) <<< 16;
            td = 128'(c) <<< 16;
         end else if (sn > sd) begin
            sn = sd;
            tn = 128'(e + b) <<< 16;
            td = 128'(c) <<< 16;
         end
      end
      // clamp t, then recompute s against the clamped edge
      redo_s = 1'b1;
      nd = 0;
      if (tn < 0) begin
         tn = 0;
         nd = -d;
      end else if (tn > td) begin
         tn = td;
         nd = b - d;
      end else begin
         redo_s = 1'b0;
      end
      if (redo_s) begin
         if (nd < 0) sn = 0;
         else if (nd > a) sn = sd;
         else begin
            sn = 128'(nd) <<< 16;
            sd = 128'(a) <<< 16;
         end
      end
      sc = clamp_ratio(sn, sd);
      tc = clamp_ratio(tn, td);
      for (int k = 0; k < 3; k++) begin
         comp = (w[k] <<< QFRAC) + $signed(sc) * u[k] - $signed(tc) * v[k];
         mag = comp < 0 ? -comp : comp;
         q = (mag + (64'd1 << 23)) >> 24;
         sum += q * q;
      end
      r = int_sqrt(sum);
      g = (r + 64'd128) >> 8;
      return g > 64'(OUT_MAX) ? OUT_MAX : g[OUT_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Pick a coordinate: mostly uniform random, sometimes near zero or at the extremes.
   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2, 3: return 16'($urandom_range(0, 2047) - 1024);
         default: return 16'($urandom);
      endcase
   endfunction

   // Driver: hold the request until accepted, advance from the queue.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_segments.size() != 0 && !hold_sender &&
             (no_idle || $urandom_range(0, 99) >= 17)) begin
            req_tdata  <= pending_segments.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Predict at acceptance of each request.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         expected_gaps.push_back(predict_gap(req_tdata));
   end

   // Monitor: stall at random, compare each accepted result with the oldest guess.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || $urandom_range(0, 99) >= 17;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_gaps.size() == 0)
               report_mismatch("result with no request outstanding");
            else if (rsp_tdata !== OUT_TDATA_W'(expected_gaps[0]))
               report_mismatch($sformatf("gap_length got %h expected %h",
                                         rsp_tdata, expected_gaps[0]));
            if (expected_gaps.size() != 0) void'(expected_gaps.pop_front());
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else if (!stim_done || expected_gaps.size() != 0) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic push_item(input logic [15:0] c[12]);
      logic [IN_W-1:0] item;
      for (int k = 0; k < 12; k++) item[k*16 +: 16] = c[k];
      pending_segments.push_back(item);
   endtask

   initial begin
      logic [15:0] c[12];
      logic [15:0] base, off;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: all zero, all extremes, degenerate and parallel segments
      foreach (c[k]) c[k] = 16'h0000;
      push_item(c);
      foreach (c[k]) c[k] = 16'h7FFF;
      push_item(c);
      foreach (c[k]) c[k] = 16'h8000;
      push_item(c);
      foreach (c[k]) c[k] = 16'hFFFF;
      push_item(c);
      // opposite corners: the longest possible distance
      foreach (c[k]) c[k] = k < 6 ? 16'h8000 : 16'h7FFF;
      push_item(c);
      foreach (c[k]) c[k] = (k % 2) ? 16'h8000 : 16'h7FFF;
      push_item(c);
      // zero-length A, zero-length B, both
      c = '{16'h0100, 16'h0200, 16'h0300, 16'h0100, 16'h0200, 16'h0300,
            16'h0000, 16'h0000, 16'h0000, 16'h0500, 16'hFF00, 16'h0000};
      push_item(c);
      c = '{16'h0000, 16'h0000, 16'h0000, 16'h0400, 16'h0100, 16'h0000,
            16'h0200, 16'h0300, 16'h0100, 16'h0200, 16'h0300, 16'h0100};
      push_item(c);
      c = '{16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
            16'hFF00, 16'h0000, 16'h0000, 16'hFF00, 16'h0000, 16'h0000};
      push_item(c);
      // parallel, overlapping and disjoint
      c = '{16'h0000, 16'h0000, 16'h0000, 16'h0A00, 16'h0000, 16'h0000,
            16'h0200, 16'h0100, 16'h0000, 16'h0800, 16'h0100, 16'h0000};
      push_item(c);
      c = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
            16'h0500, 16'h0100, 16'h0000, 16'h0300, 16'h0100, 16'h0000};
      push_item(c);
      // crossing segments, skew segments, clamped ends
      c = '{16'hFF00, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
            16'h0000, 16'hFF00, 16'h0100, 16'h0000, 16'h0100, 16'h0100};
      push_item(c);
      c = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
            16'h0300, 16'h0200, 16'h0000, 16'h0300, 16'h0500, 16'h0001};
      push_item(c);
      c = '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0000,
            16'h0000, 16'h0001, 16'h0000, 16'h0001, 16'h0000, 16'h0001};
      push_item(c);
      c = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
            16'hFE00, 16'h0100, 16'h0000, 16'hFD00, 16'h0200, 16'h0000};
      push_item(c);

      // wait until the directed results are all back, then pause the sender
      wait (pending_segments.size() == 0 && expected_gaps.size() == 0);
      @(posedge clock);
      hold_sender <= 1'b1;
      repeat (LATENCY) @(posedge clock);
      hold_sender <= 1'b0;

      // random: small clusters near a shared base, near-parallel pairs, raw noise
      for (int n = 0; n < 1050; n++) begin
         if (n == 400) begin
            wait (pending_segments.size() == 0);
            no_idle <= 1'b1;
         end
         if (n == 600) begin
            wait (pending_segments.size() == 0);
            no_idle <= 1'b0;
         end
         case ($urandom_range(0, 3))
            0: foreach (c[k]) c[k] = pick_coord();
            1: begin
               base = 16'($urandom);
               foreach (c[k]) c[k] = base + 16'($urandom_range(0, 1023) - 512);
            end
            2: begin
               foreach (c[k]) c[k] = (k < 6) ? 16'($urandom) : 16'h0;
               off = 16'($urandom_range(0, 255));
               for (int k = 0; k < 6; k++) c[6+k] = c[k] + off + 16'($urandom_range(0, 1));
            end
            default: foreach (c[k]) c[k] = 16'($urandom_range(0, 8191) - 4096);
         endcase
         push_item(c);
      end

      wait (pending_segments.size() == 0 && !req_tvalid);
      stim_done = 1'b1;
      wait (expected_gaps.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
